>>> design/scta_pkg.sv
// Shared types, constants and widths for the symmetrical component transform.
// Used by every module of the block; depends on nothing.
package scta_pkg;

   // Q0.16 constants
   localparam logic signed [17:0] SQRT3_HALF_Q16 = 18'sd56756;
   localparam logic [14:0]        THIRD_Q16      = 15'd21845;

   // Exact part sums in units of 2^-16 input LSB
   localparam int SUM_W  = 36;
   // Forward scaling product (sum times one third)
   localparam int WIDE_W = 54;
   // Rounded value before clipping
   localparam int RES_W  = 22;

   typedef logic signed [SUM_W-1:0]  part_type;
   typedef logic signed [WIDE_W-1:0] wide_type;
   typedef logic signed [RES_W-1:0]  res_type;

   // Control that travels with each item down the pipeline
   typedef struct packed {
      logic valid;
      logic inverse;
   } ctl_type;

   typedef struct packed {
      logic signed [15:0] in0_re;
      logic signed [15:0] in0_im;
      logic signed [15:0] in1_re;
      logic signed [15:0] in1_im;
      logic signed [15:0] in2_re;
      logic signed [15:0] in2_im;
   } req_type;

   typedef struct packed {
      logic signed [15:0] out0_re;
      logic signed [15:0] out0_im;
      logic signed [15:0] out1_re;
      logic signed [15:0] out1_im;
      logic signed [15:0] out2_re;
      logic signed [15:0] out2_im;
      logic               saturated;
   } rsp_type;

   // First-stage terms: plain sums, in-phase deviations, quadrature differences
   typedef struct packed {
      logic signed [17:0] sum_re;
      logic signed [17:0] sum_im;
      logic signed [18:0] dev_re;
      logic signed [18:0] dev_im;
      logic signed [16:0] diff_re;
      logic signed [16:0] diff_im;
   } prep_type;

endpackage

>>> design/symmetrical_component_transform_unit.sv
// Top level of the symmetrical component transform: direction register, input
// register and the pipeline. Depends on scta_pkg, scta_prep, scta_rotate, scta_scale.
//
//   channel   ports                       flow
//   request   start, busy, req_data       in, transfer when start and not busy
//   response  rsp_strobe, rsp_data        out, one cycle per result, no back-pressure
//   config    csr_we, csr_wdata           in, direction bit, written when csr_we
//
// One triple enters per cycle; busy is always low. Each result passes, after its
// transfer, through the input register, sum/difference stage, sqrt(3)/2
// multiply, part sums, one-third partial products and round/clip/output register.
// Reset clears the direction and every valid bit; payload registers are not reset.
// Nothing stalls: the receiver takes every strobe, so the pipeline just advances.
module symmetrical_component_transform_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  scta_pkg::req_type req_data,
   output logic              rsp_strobe,
   output scta_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_wdata
);

   logic               direction_ff;
   scta_pkg::ctl_type  in_ctl_ff;
   scta_pkg::ctl_type  in_ctl_in;
   scta_pkg::req_type  req_ff;
   scta_pkg::ctl_type  prep_ctl;
   scta_pkg::prep_type prep_data;
   scta_pkg::ctl_type  part_ctl;
   scta_pkg::part_type part_data [6];

   assign busy = 1'b0;

   // Direction register
   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
      end else if (csr_we) begin
         direction_ff <= csr_wdata;
      end
   end

   // Input register, direction travels with the item
   assign in_ctl_in.valid   = start & ~busy;
   assign in_ctl_in.inverse = direction_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ctl_ff <= '0;
      end else begin
         in_ctl_ff <= in_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_data;
   end

   scta_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .ctl_in   (in_ctl_ff),
      .req_in   (req_ff),
      .ctl_out  (prep_ctl),
      .prep_out (prep_data)
   );

   scta_rotate u_rotate (
      .clock    (clock),
      .reset    (reset),
      .ctl_in   (prep_ctl),
      .prep_in  (prep_data),
      .ctl_out  (part_ctl),
      .part_out (part_data)
   );

   scta_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .ctl_in     (part_ctl),
      .part_in    (part_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // Every strobe traces back to an earlier transfer
   a_strobe_from_transfer: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 6))
      else $error("result strobe without matching transfer");

   // Every transfer produces a later strobe
   a_transfer_to_strobe: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##6 rsp_strobe)
      else $error("transfer lost in pipeline");

   // Saturation flag only with some part at a rail
   a_sat_at_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.saturated) |->
         (rsp_data.out0_re == 16'sh7fff || rsp_data.out0_re == 16'sh8000 ||
          rsp_data.out0_im == 16'sh7fff || rsp_data.out0_im == 16'sh8000 ||
          rsp_data.out1_re == 16'sh7fff || rsp_data.out1_re == 16'sh8000 ||
          rsp_data.out1_im == 16'sh7fff || rsp_data.out1_im == 16'sh8000 ||
          rsp_data.out2_re == 16'sh7fff || rsp_data.out2_re == 16'sh8000 ||
          rsp_data.out2_im == 16'sh7fff || rsp_data.out2_im == 16'sh8000))
      else $error("saturated flag with no clipped part");

endmodule

>>> design/scta_prep.sv
// First pipeline stage: sums and differences of the three input phasors.
// Depends on scta_pkg.
module scta_prep (
   input  logic               clock,
   input  logic               reset,
   input  scta_pkg::ctl_type  ctl_in,
   input  scta_pkg::req_type  req_in,
   output scta_pkg::ctl_type  ctl_out,
   output scta_pkg::prep_type prep_out
);

   scta_pkg::ctl_type  ctl_ff;
   scta_pkg::prep_type prep_ff;
   scta_pkg::prep_type prep_in;

   // Direction only flips the sign of the quadrature differences
   always_comb begin
      prep_in.sum_re = 18'(req_in.in0_re) + 18'(req_in.in1_re) + 18'(req_in.in2_re);
      prep_in.sum_im = 18'(req_in.in0_im) + 18'(req_in.in1_im) + 18'(req_in.in2_im);
      prep_in.dev_re = (19'(req_in.in0_re) <<< 1) - 19'(req_in.in1_re) - 19'(req_in.in2_re);
      prep_in.dev_im = (19'(req_in.in0_im) <<< 1) - 19'(req_in.in1_im) - 19'(req_in.in2_im);
      if (ctl_in.inverse) begin
         prep_in.diff_re = 17'(req_in.in2_re) - 17'(req_in.in1_re);
         prep_in.diff_im = 17'(req_in.in1_im) - 17'(req_in.in2_im);
      end else begin
         prep_in.diff_re = 17'(req_in.in1_re) - 17'(req_in.in2_re);
         prep_in.diff_im = 17'(req_in.in2_im) - 17'(req_in.in1_im);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      prep_ff <= prep_in;
   end

   assign ctl_out  = ctl_ff;
   assign prep_out = prep_ff;

endmodule

>>> design/scta_rotate.sv
// Stages two and three: sqrt(3)/2 products, then the six exact part sums.
// Depends on scta_pkg.
module scta_rotate (
   input  logic               clock,
   input  logic               reset,
   input  scta_pkg::ctl_type  ctl_in,
   input  scta_pkg::prep_type prep_in,
   output scta_pkg::ctl_type  ctl_out,
   output scta_pkg::part_type part_out [6]
);

   scta_pkg::ctl_type  mul_ctl_ff;
   scta_pkg::ctl_type  sum_ctl_ff;
   logic signed [17:0] sum_re_ff;
   logic signed [17:0] sum_im_ff;
   logic signed [18:0] dev_re_ff;
   logic signed [18:0] dev_im_ff;
   scta_pkg::part_type rot_re_ff;
   scta_pkg::part_type rot_im_ff;
   scta_pkg::part_type rot_re_in;
   scta_pkg::part_type rot_im_in;
   scta_pkg::part_type part_ff [6];
   scta_pkg::part_type part_in [6];
   scta_pkg::part_type base_re;
   scta_pkg::part_type base_im;

   // Quadrature terms scaled by sqrt(3)/2
   assign rot_re_in = scta_pkg::part_type'(prep_in.diff_re)
                    * scta_pkg::part_type'(scta_pkg::SQRT3_HALF_Q16);
   assign rot_im_in = scta_pkg::part_type'(prep_in.diff_im)
                    * scta_pkg::part_type'(scta_pkg::SQRT3_HALF_Q16);

   always_ff @(posedge clock) begin
      rot_re_ff <= rot_re_in;
      rot_im_ff <= rot_im_in;
      sum_re_ff <= prep_in.sum_re;
      sum_im_ff <= prep_in.sum_im;
      dev_re_ff <= prep_in.dev_re;
      dev_im_ff <= prep_in.dev_im;
   end

   // In-phase part is a multiple of one half, so it is a shift
   always_comb begin
      base_re    = scta_pkg::part_type'(dev_re_ff) <<< 15;
      base_im    = scta_pkg::part_type'(dev_im_ff) <<< 15;
      part_in[0] = scta_pkg::part_type'(sum_re_ff) <<< 16;
      part_in[1] = scta_pkg::part_type'(sum_im_ff) <<< 16;
      part_in[2] = base_re + rot_im_ff;
      part_in[3] = base_im + rot_re_ff;
      part_in[4] = base_re - rot_im_ff;
      part_in[5] = base_im - rot_re_ff;
   end

   always_ff @(posedge clock) begin
      part_ff <= part_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ctl_ff <= '0;
         sum_ctl_ff <= '0;
      end else begin
         mul_ctl_ff <= ctl_in;
         sum_ctl_ff <= mul_ctl_ff;
      end
   end

   assign ctl_out  = sum_ctl_ff;
   assign part_out = part_ff;

endmodule

>>> design/scta_scale.sv
// Stages four and five: forward one-third scaling in two partial products,
// rounding, clipping and the result register. Depends on scta_pkg.
module scta_scale (
   input  logic               clock,
   input  logic               reset,
   input  scta_pkg::ctl_type  ctl_in,
   input  scta_pkg::part_type part_in [6],
   output logic               rsp_strobe,
   output scta_pkg::rsp_type  rsp_data
);

   localparam scta_pkg::wide_type FWD_HALF = scta_pkg::wide_type'(64'sd2147483648);
   localparam logic signed [scta_pkg::SUM_W:0] INV_HALF = (scta_pkg::SUM_W+1)'(32768);
   localparam scta_pkg::res_type  RES_MAX  = scta_pkg::res_type'(32767);
   localparam scta_pkg::res_type  RES_MIN  = -scta_pkg::res_type'(32768);

   scta_pkg::ctl_type  mul_ctl_ff;
   logic               strobe_ff;
   scta_pkg::part_type part_ff [6];
   scta_pkg::part_type hi_ff [6];
   scta_pkg::part_type hi_in [6];
   logic [30:0]        lo_ff [6];
   logic [30:0]        lo_in [6];
   scta_pkg::rsp_type  rsp_ff;
   scta_pkg::rsp_type  rsp_in;

   scta_pkg::wide_type             fwd_sum [6];
   logic signed [scta_pkg::SUM_W:0] inv_sum [6];
   scta_pkg::res_type              rnd [6];
   logic signed [15:0]             clip [6];
   logic [5:0]                     clipped;

   // Sum times 21845, split at bit 16 into signed high and unsigned low halves
   always_comb begin
      for (int k = 0; k < 6; k++) begin
         hi_in[k] = scta_pkg::part_type'($signed(part_in[k][scta_pkg::SUM_W-1:16]))
                  * scta_pkg::part_type'($signed({1'b0, scta_pkg::THIRD_Q16}));
         lo_in[k] = 31'(part_in[k][15:0]) * 31'(scta_pkg::THIRD_Q16);
      end
   end

   always_ff @(posedge clock) begin
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      part_ff <= part_in;
   end

   // Round half up, then clip each part to 16 bits
   always_comb begin
      for (int k = 0; k < 6; k++) begin
         fwd_sum[k] = (scta_pkg::wide_type'(hi_ff[k]) <<< 16)
                    + scta_pkg::wide_type'($signed({1'b0, lo_ff[k]})) + FWD_HALF;
         inv_sum[k] = (scta_pkg::SUM_W+1)'(part_ff[k]) + INV_HALF;
         if (mul_ctl_ff.inverse) begin
            rnd[k] = scta_pkg::res_type'($signed(inv_sum[k][scta_pkg::SUM_W:16]));
         end else begin
            rnd[k] = $signed(fwd_sum[k][scta_pkg::WIDE_W-1:32]);
         end
         priority if (rnd[k] > RES_MAX) begin
            clip[k]    = 16'sh7fff;
            clipped[k] = 1'b1;
         end else if (rnd[k] < RES_MIN) begin
            clip[k]    = 16'sh8000;
            clipped[k] = 1'b1;
         end else begin
            clip[k]    = rnd[k][15:0];
            clipped[k] = 1'b0;
         end
      end
      rsp_in.out0_re   = clip[0];
      rsp_in.out0_im   = clip[1];
      rsp_in.out1_re   = clip[2];
      rsp_in.out1_im   = clip[3];
      rsp_in.out2_re   = clip[4];
      rsp_in.out2_im   = clip[5];
      rsp_in.saturated = |clipped;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ctl_ff <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         mul_ctl_ff <= ctl_in;
         strobe_ff  <= mul_ctl_ff.valid;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
